### hdl/lzwbe_pkg.sv
package lzwbe_pkg;

   localparam int CODE_BITS_DEF     = 12;
   localparam int TABLE_ENTRIES_DEF = 8192;
   localparam int SYM_W             = 7;
   localparam int OUT_CODE_W        = 12;
   localparam int LIMIT_W           = 12;
   localparam int CMP_W             = 17;
   localparam int EPOCH_W           = 8;
   localparam int FIRST_FREE        = 127;
   localparam int CSR_ADDR_W        = 3;
   localparam int CSR_DATA_W        = 32;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 12'd4095;
   localparam logic [31:0]        HASH_MUL_PRE  = 32'd131;
   localparam logic [31:0]        HASH_MUL_CH   = 32'd2654435761;
   localparam int                 HASH_SHIFT    = 13;
   localparam logic [0:0]         REG_CODE_LIMIT = 1'b0;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_READ,
      ST_CHECK,
      ST_EMIT,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic take_in;
      logic set_first;
      logic load_hash;
      logic rd_en;
      logic step;
      logic mark_free;
      logic mark_none;
      logic hit;
      logic miss_emit;
      logic finish;
      logic clear_start;
      logic clear_wr;
   } cmd_type;

   typedef struct packed {
      logic ch_nonzero;
      logic prefix_valid;
      logic last;
      logic slot_empty;
      logic slot_match;
      logic probe_full;
      logic out_free;
      logic clear_done;
      logic epoch_wrap;
   } sts_type;

endpackage

### hdl/lzwbe_ram.sv
module lzwbe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end
endmodule

### hdl/lzwbe_ctrl.sv
module lzwbe_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lzwbe_pkg::sts_type sts,
   output lzwbe_pkg::cmd_type cmd
);
   import lzwbe_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_in = 1'b1;
               state_in    = ST_HASH;
            end
         end
         ST_HASH: begin
            priority if (sts.ch_nonzero && sts.prefix_valid) begin
               cmd.load_hash = 1'b1;
               state_in      = ST_READ;
            end else if (sts.ch_nonzero) begin
               cmd.set_first = 1'b1;
               state_in      = ST_FIN;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            priority if (sts.slot_empty) begin
               cmd.mark_free = 1'b1;
               state_in      = ST_EMIT;
            end else if (sts.slot_match) begin
               cmd.hit  = 1'b1;
               state_in = ST_FIN;
            end else if (sts.probe_full) begin
               cmd.mark_none = 1'b1;
               state_in      = ST_EMIT;
            end else begin
               cmd.step = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.miss_emit = 1'b1;
               state_in      = ST_FIN;
            end
         end
         ST_FIN: begin
            priority if (!sts.last) begin
               state_in = ST_IDLE;
            end else if (sts.prefix_valid && !sts.out_free) begin
               state_in = ST_FIN;
            end else begin
               cmd.finish = 1'b1;
               if (sts.epoch_wrap) begin
                  cmd.clear_start = 1'b1;
                  state_in        = ST_CLEAR;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end
endmodule

### hdl/lzwbe_dpath.sv
module lzwbe_dpath #(
   parameter int CODE_BITS     = lzwbe_pkg::CODE_BITS_DEF,
   parameter int TABLE_ENTRIES = lzwbe_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lzwbe_pkg::cmd_type                cmd,
   output lzwbe_pkg::sts_type                sts,
   input  logic [lzwbe_pkg::LIMIT_W-1:0]     code_limit,
   input  logic [lzwbe_pkg::SYM_W-1:0]       req_symbol,
   input  logic                              req_last_symbol,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [lzwbe_pkg::OUT_CODE_W-1:0]  rsp_code,
   output logic                              rsp_last_code
);
   import lzwbe_pkg::*;

   localparam int IDX_BITS = $clog2(TABLE_ENTRIES);
   localparam int ENTRY_W  = EPOCH_W + 2 * CODE_BITS + SYM_W;
   localparam logic [CMP_W-1:0] CODE_MASK = CMP_W'((1 << CODE_BITS) - 1);

   logic [SYM_W-1:0]     ch_ff;
   logic                 last_ff;
   logic [CODE_BITS-1:0] prefix_ff;
   logic                 pvalid_ff;
   logic [CODE_BITS:0]   nfree_ff;
   logic [IDX_BITS-1:0]  idx_ff, cnt_ff, clr_cnt_ff;
   logic                 slot_ok_ff;
   logic [EPOCH_W-1:0]   epoch_ff;
   logic                 rsp_valid_ff;
   logic [OUT_CODE_W-1:0] rsp_code_ff;
   logic                 rsp_last_ff;

   logic [31:0]          h0, h1;
   logic [ENTRY_W-1:0]   rdata, wdata;
   logic                 we;
   logic [IDX_BITS-1:0]  waddr;
   logic [EPOCH_W-1:0]   e_epoch;
   logic [CODE_BITS-1:0] e_prefix, e_code;
   logic [SYM_W-1:0]     e_char;
   logic [CMP_W-1:0]     eff_limit, pre_ext;
   logic                 can_add, out_free, emit;
   logic [CODE_BITS-1:0] first_code;

   // hash of the (prefix, character) pair
   assign h0 = (32'(prefix_ff) * HASH_MUL_PRE) ^ (32'(ch_ff) * HASH_MUL_CH);
   assign h1 = h0 ^ (h0 >> HASH_SHIFT);

   assign {e_epoch, e_prefix, e_char, e_code} = rdata;

   assign eff_limit = (CMP_W'(code_limit) < CODE_MASK) ? CMP_W'(code_limit) : CODE_MASK;
   assign can_add   = slot_ok_ff && (CMP_W'(nfree_ff) <= eff_limit);
   assign pre_ext   = CMP_W'(prefix_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign first_code = CODE_BITS'(ch_ff) - CODE_BITS'(1);
   assign emit      = cmd.miss_emit || (cmd.finish && pvalid_ff);

   assign we    = cmd.clear_wr || (cmd.miss_emit && can_add);
   assign waddr = cmd.clear_wr ? clr_cnt_ff : idx_ff;
   assign wdata = cmd.clear_wr ? '0 : {epoch_ff, prefix_ff, ch_ff, nfree_ff[CODE_BITS-1:0]};

   lzwbe_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_dict (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (cmd.rd_en),
      .raddr (idx_ff),
      .rdata (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff    <= 1'b0;
         prefix_ff    <= '0;
         nfree_ff     <= (CODE_BITS+1)'(FIRST_FREE);
         epoch_ff     <= EPOCH_W'(1);
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.set_first) begin
            prefix_ff <= first_code;
            pvalid_ff <= 1'b1;
         end
         if (cmd.hit) prefix_ff <= e_code;
         if (cmd.miss_emit) begin
            prefix_ff <= first_code;
            if (can_add) nfree_ff <= nfree_ff + 1'b1;
         end
         if (cmd.finish) begin
            pvalid_ff <= 1'b0;
            prefix_ff <= '0;
            nfree_ff  <= (CODE_BITS+1)'(FIRST_FREE);
            epoch_ff  <= sts.epoch_wrap ? EPOCH_W'(1) : epoch_ff + 1'b1;
         end
         if (cmd.clear_start) clr_cnt_ff <= '0;
         else if (cmd.clear_wr) clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (emit) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_in) begin
         ch_ff   <= req_symbol;
         last_ff <= req_last_symbol;
      end
      if (cmd.load_hash) begin
         idx_ff <= h1[IDX_BITS-1:0];
         cnt_ff <= '0;
      end else if (cmd.step) begin
         idx_ff <= idx_ff + 1'b1;
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.mark_free) slot_ok_ff <= 1'b1;
      if (cmd.mark_none) slot_ok_ff <= 1'b0;
      if (emit) begin
         rsp_code_ff <= pre_ext[OUT_CODE_W-1:0];
         rsp_last_ff <= cmd.finish;
      end
   end

   always_comb begin
      sts.ch_nonzero   = (ch_ff != '0);
      sts.prefix_valid = pvalid_ff;
      sts.last         = last_ff;
      // an entry from an earlier message carries a stale epoch
      sts.slot_empty   = (e_epoch != epoch_ff);
      sts.slot_match   = (e_prefix == prefix_ff) && (e_char == ch_ff);
      sts.probe_full   = (cnt_ff == IDX_BITS'(TABLE_ENTRIES - 1));
      sts.out_free     = out_free;
      sts.clear_done   = (clr_cnt_ff == IDX_BITS'(TABLE_ENTRIES - 1));
      sts.epoch_wrap   = (epoch_ff == '1);
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_code      = rsp_code_ff;
   assign rsp_last_code = rsp_last_ff;
endmodule

### hdl/lzw_byte_encoder_core.sv
// a lookup passes through hash, ram read and compare, with a further ram read and compare per
// collision probe; a character that needs no lookup skips these; a final code after a miss follows the miss code
// a new character is taken only once the previous one is through, and a miss or a final code
// also waits for a free result register
// reset: synchronous; a clearing pass over all TABLE_ENTRIES entries follows reset and every 255th
// message end, during which no character is taken; register writes are taken always
module lzw_byte_encoder_core #(
   parameter int CODE_BITS     = lzwbe_pkg::CODE_BITS_DEF,
   parameter int TABLE_ENTRIES = lzwbe_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [lzwbe_pkg::SYM_W-1:0]       req_symbol,
   input  logic                              req_last_symbol,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [lzwbe_pkg::OUT_CODE_W-1:0]  rsp_code,
   output logic                              rsp_last_code,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lzwbe_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [lzwbe_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [lzwbe_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                              csr_pready
);
   import lzwbe_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic [LIMIT_W-1:0] limit_ff;
   logic               sel_limit;

   assign sel_limit  = (csr_paddr[CSR_ADDR_W-1] == REG_CODE_LIMIT)
                       && (csr_paddr[CSR_ADDR_W-2:0] == '0);
   assign csr_pready = 1'b1;
   assign csr_prdata = sel_limit ? CSR_DATA_W'(limit_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && sel_limit) begin
         limit_ff <= csr_pwdata[LIMIT_W-1:0];
      end
   end

   lzwbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lzwbe_dpath #(.CODE_BITS(CODE_BITS), .TABLE_ENTRIES(TABLE_ENTRIES)) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .code_limit      (limit_ff),
      .req_symbol      (req_symbol),
      .req_last_symbol (req_last_symbol),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_code        (rsp_code),
      .rsp_last_code   (rsp_last_code)
   );
endmodule

### hdl/lzwbe_checker.sv
module lzwbe_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [lzwbe_pkg::OUT_CODE_W-1:0]  rsp_code,
   input logic                              csr_psel,
   input logic                              csr_penable,
   input logic                              csr_pwrite,
   input logic [lzwbe_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input logic [lzwbe_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   input logic [lzwbe_pkg::CSR_DATA_W-1:0]  csr_prdata
);
   import lzwbe_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code))
      else $error("result changed while stalled");

   // one character per transaction, never two in a row
   a_req_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after accepted transaction");

   a_reset_quiet: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid && !req_ready)
      else $error("activity right after reset");

   a_limit_readback: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_paddr == '0)
      ##1 (csr_paddr == '0) |-> csr_prdata[LIMIT_W-1:0] == $past(csr_pwdata[LIMIT_W-1:0]))
      else $error("code limit readback mismatch");
endmodule

bind lzw_byte_encoder_core lzwbe_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_code    (rsp_code),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata)
);
